/* design/mnts_pkg.sv */
// ----------------------------------------------------------------------------
// mnts_pkg
// Shared types, constants and helpers for the MIDI note tracker.
// ----------------------------------------------------------------------------
package mnts_pkg;

    localparam int KEY_COUNT = 128;
    localparam int HALF_KEYS = KEY_COUNT / 2;
    localparam int ROW_W     = 2 * HALF_KEYS;   // {sustained, pressed}
    localparam int ROWS      = KEY_COUNT / HALF_KEYS;

    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_AFTER    = 4'hA;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_BEND     = 4'hE;

    localparam logic [6:0] SUSTAIN_CC  = 7'd64;
    localparam logic [6:0] VEL_MAX     = 7'd127;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_MASK = 1'b1;

    typedef enum logic [2:0] {
        S1_NOTE   = 3'b001,
        S1_PED_LO = 3'b010,
        S1_PED_HI = 3'b100
    } t_s1_op;

    typedef struct packed {
        logic                 kind;
        logic [6:0]           note_key;
        logic [6:0]           velocity;
        logic                 recorded;
        logic signed [15:0]   delta_ticks;
        logic [6:0]           raw_velocity;
        logic                 mask_half;
        logic [HALF_KEYS-1:0] release_mask;
        logic                 last;
    } t_res;

    function automatic logic takes_value(input logic [3:0] st);
        return (st == ST_NOTE_OFF) || (st == ST_NOTE_ON) || (st == ST_AFTER) ||
               (st == ST_CTRL) || (st == ST_BEND);
    endfunction

    // v*4/3 through a reciprocal multiply, exact for v*4 below 2048
    function automatic logic [6:0] scale_vel(input logic [6:0] v);
        logic [18:0] prod;
        logic [7:0]  quot;
        prod = 19'({v, 2'b00}) * 19'd683;
        quot = prod[18:11];
        return (quot > 8'(VEL_MAX)) ? VEL_MAX : quot[6:0];
    endfunction

endpackage

/* design/midi_note_tracker_with_sustain_core.sv */
// ----------------------------------------------------------------------------
// midi_note_tracker_with_sustain_core
// MIDI byte parser with running status, key bitmaps and sustain pedal.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                 Payload
// s         in   i_s_tvalid / o_s_tready   tdata: midi_byte, now_tick
// m         out  o_m_tvalid / i_m_tready   tdata, tuser: kind, tlast: last
// cfg       in   i_cfg_we                  i_cfg_wdata: record_enable
//
// One item per cycle while o_s_tready is high; a note result is pushed to the queue
// from stage 1 (bitmap RAM read, then modify/write with forwarding).
// A pedal release walks both bitmap rows and holds the input while the low row is processed.
// Results queue in an OUT_DEPTH entry buffer; input stalls when it may fill.
// Reset clears parser state and row valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module midi_note_tracker_with_sustain_core
    import mnts_pkg::*;
#(
    parameter int OUT_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [39:0]  i_s_tdata,   // midi_byte[7:0], now_tick[39:8]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // note_key[6:0], velocity[13:7], recorded[14],
                                      // delta_ticks[30:15], raw_velocity[37:31],
                                      // mask_half[38], release_mask[102:39], pad[103]
    output logic         o_m_tuser,   // kind
    output logic         o_m_tlast,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata
);

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int ROW_A = $clog2(ROWS);

    logic              in_acc;
    logic [7:0]        midi;
    logic [31:0]       tick;

    logic              r_rec_en;
    logic [3:0]        r_status;
    logic              r_phase;
    logic [6:0]        r_held;
    logic              r_pedal;
    logic [31:0]       r_last_tick;
    logic [ROWS-1:0]   r_row_valid;
    logic [ROWS-1:0]   r_sust_nz;

    logic              s0_note;
    logic              s0_ped_upd;
    logic              s0_ped_rel;

    logic              r_s1_valid, n_s1_valid;
    t_s1_op            r_s1_op, n_s1_op;
    logic [ROW_A-1:0]  r_s1_row, n_s1_row;
    logic [6:0]        r_s1_key, r_s1_raw, r_s1_scaled;
    logic [31:0]       r_s1_tick;

    logic              r_fw_valid;
    logic [ROW_A-1:0]  r_fw_row;
    logic [ROW_W-1:0]  r_fw_data;

    logic [ROW_W-1:0]  ram_q;
    logic [ROW_W-1:0]  row_cur;
    logic [HALF_KEYS-1:0] pres, sust, new_pres, new_sust, key_bit;

    logic              s1_push, s1_stall, s1_adv, s1_rec;
    t_res              s1_res;

    t_res              r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push, pop;
    t_res              head;

    assign midi   = i_s_tdata[7:0];
    assign tick   = i_s_tdata[39:8];
    assign in_acc = i_s_tvalid && o_s_tready;

    assign o_s_tready = !(r_s1_valid && (r_s1_op == S1_PED_LO)) &&
        ((CNT_W+1)'(r_count) + (CNT_W+1)'(r_s1_valid) <= (CNT_W+1)'(OUT_DEPTH - 2));

    // ---- parse ----
    always_comb begin
        s0_note    = 1'b0;
        s0_ped_upd = 1'b0;
        s0_ped_rel = 1'b0;
        if (in_acc && !midi[7] && r_phase) begin
            if (r_status == ST_NOTE_ON) begin
                s0_note = 1'b1;
            end else if (r_status == ST_CTRL && r_held == SUSTAIN_CC) begin
                s0_ped_upd = 1'b1;
                s0_ped_rel = (midi[6:0] == 7'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= 4'd0;
            r_phase  <= 1'b0;
            r_held   <= 7'd0;
            r_pedal  <= 1'b0;
            r_rec_en <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rec_en <= i_cfg_wdata;
            end
            if (in_acc) begin
                if (midi[7]) begin
                    r_status <= midi[7:4];
                    r_phase  <= 1'b0;
                end else if (!r_phase) begin
                    if (takes_value(r_status)) begin
                        r_held  <= midi[6:0];
                        r_phase <= 1'b1;
                    end
                end else begin
                    r_phase <= 1'b0;
                end
            end
            if (s0_ped_upd) begin
                r_pedal <= !s0_ped_rel;
            end
        end
    end

    // ---- stage 1 control ----
    always_comb begin
        n_s1_valid = 1'b0;
        n_s1_op    = r_s1_op;
        n_s1_row   = r_s1_row;
        if (s1_stall) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv && r_s1_op == S1_PED_LO) begin
            n_s1_valid = 1'b1;
            n_s1_op    = S1_PED_HI;
            n_s1_row   = ROW_A'(1);
        end else if (s0_note) begin
            n_s1_valid = 1'b1;
            n_s1_op    = S1_NOTE;
            n_s1_row   = ROW_A'(r_held[6]);
        end else if (s0_ped_rel) begin
            n_s1_valid = 1'b1;
            n_s1_op    = S1_PED_LO;
            n_s1_row   = ROW_A'(0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_op    <= S1_NOTE;
            r_s1_row   <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s1_op    <= n_s1_op;
            r_s1_row   <= n_s1_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_note) begin
            r_s1_key    <= r_held;
            r_s1_raw    <= midi[6:0];
            r_s1_scaled <= scale_vel(midi[6:0]);
            r_s1_tick   <= tick;
        end
    end

    // ---- bitmap RAM ----
    mnts_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_row),
        .i_wdata ({new_sust, new_pres}),
        .i_raddr (n_s1_row),
        .o_rdata (ram_q)
    );

    always_comb begin
        if (r_fw_valid && r_fw_row == r_s1_row) begin
            row_cur = r_fw_data;
        end else if (r_row_valid[r_s1_row]) begin
            row_cur = ram_q;
        end else begin
            row_cur = '0;
        end
    end

    assign pres    = row_cur[HALF_KEYS-1:0];
    assign sust    = row_cur[ROW_W-1:HALF_KEYS];
    assign key_bit = HALF_KEYS'(1) << r_s1_key[5:0];

    // ---- stage 1 modify ----
    always_comb begin
        new_pres = pres;
        new_sust = sust;
        s1_push  = 1'b0;
        s1_rec   = 1'b0;
        s1_res   = '0;
        unique case (r_s1_op)
            S1_NOTE: begin
                s1_res.kind     = KIND_NOTE;
                s1_res.note_key = r_s1_key;
                s1_res.last     = 1'b1;
                if (r_s1_raw != 7'd0) begin
                    new_pres        = pres | key_bit;
                    new_sust        = sust & ~key_bit;
                    s1_push         = 1'b1;
                    s1_res.velocity = r_s1_scaled;
                end else if ((pres & key_bit) != '0) begin
                    new_pres = pres & ~key_bit;
                    if (r_pedal) begin
                        new_sust = sust | key_bit;
                    end else begin
                        s1_push = 1'b1;
                    end
                end
                if (s1_push && r_rec_en) begin
                    s1_rec                = 1'b1;
                    s1_res.recorded       = 1'b1;
                    s1_res.delta_ticks    = r_s1_tick[15:0] - r_last_tick[15:0];
                    s1_res.raw_velocity   = r_s1_raw;
                end
            end
            S1_PED_LO, S1_PED_HI: begin
                new_sust            = '0;
                s1_push             = (sust != '0);
                s1_res.kind         = KIND_MASK;
                s1_res.mask_half    = (r_s1_op == S1_PED_HI);
                s1_res.release_mask = sust;
                s1_res.last         = (r_s1_op == S1_PED_HI) || !r_sust_nz[1];
            end
            default: begin
                new_pres = pres;
            end
        endcase
    end

    assign s1_stall = r_s1_valid && s1_push && (r_count == CNT_W'(OUT_DEPTH));
    assign s1_adv   = r_s1_valid && !s1_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid  <= 1'b0;
            r_row_valid <= '0;
            r_sust_nz   <= '0;
            r_last_tick <= 32'd0;
        end else begin
            r_fw_valid <= s1_adv;
            if (s1_adv) begin
                r_row_valid[r_s1_row] <= 1'b1;
                r_sust_nz[r_s1_row]   <= (new_sust != '0);
                if (s1_rec) begin
                    r_last_tick <= r_s1_tick;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_row  <= r_s1_row;
        r_fw_data <= {new_sust, new_pres};
    end

    // ---- result queue ----
    assign push = s1_adv && s1_push;
    assign pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s1_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign head       = r_fifo[r_rd_ptr];
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tuser  = head.kind;
    assign o_m_tlast  = head.last;
    assign o_m_tdata  = {1'b0, head.release_mask, head.mask_half, head.raw_velocity,
                         head.delta_ticks, head.recorded, head.velocity, head.note_key};

endmodule

/* design/mnts_ram.sv */
// ----------------------------------------------------------------------------
// mnts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mnts_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/midi_note_tracker_with_sustain_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_note_tracker_with_sustain_core_tb
// Streams MIDI bytes through the note tracker with random idling on both
// sides. A local key/pedal tracker predicts every note event and pedal mask,
// and each result item is checked field by field in order.
// ----------------------------------------------------------------------------
module midi_note_tracker_with_sustain_core_tb
    import mnts_pkg::*;
();

    localparam logic [3:0] ST_PROGRAM  = 4'hC;
    localparam logic [3:0] ST_CHAN_PRS = 4'hD;
    localparam logic [3:0] ST_SYSTEM   = 4'hF;
    localparam logic [6:0] CC_VOLUME   = 7'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 20;

    typedef struct {
        logic [7:0]  midi;
        logic [31:0] tick;
    } t_midi_in;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [39:0]  i_s_tdata = '0;   // midi_byte[7:0], now_tick[39:8]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;        // note_key, velocity, recorded, delta_ticks,
                                    // raw_velocity, mask_half, release_mask, pad
    logic         o_m_tuser;        // kind
    logic         o_m_tlast;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_wdata = 1'b0;

    midi_note_tracker_with_sustain_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // tracker state
    logic [3:0]  cur_type   = '0;
    logic        want_value = 1'b0;
    logic [7:0]  key_hold   = '0;
    logic [63:0] keys_down[2] = '{64'd0, 64'd0};
    logic [63:0] keys_held[2] = '{64'd0, 64'd0};
    logic        pedal      = 1'b0;
    logic [31:0] rec_tick   = '0;
    logic        rec_on     = 1'b0;

    t_midi_in bytes_to_send[$];
    t_res     events_due[$];

    logic [31:0] tick_now = '0;
    logic [3:0]  gen_type = '0;
    int n_err = 0, n_bytes = 0, n_notes = 0, n_masks = 0, n_results = 0, n_writes = 0;
    int cycles = 0;
    int tx_gap = 0, tx_calm = 0, rx_stall = 0, rx_calm = 0, roll = 0;
    bit hold_done = 1'b0;
    t_midi_in drv_item;
    t_res got, want;

    function automatic bit has_value(input logic [3:0] t);
        case (t)
            ST_NOTE_OFF, ST_NOTE_ON, ST_AFTER, ST_CTRL, ST_BEND: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_note(input logic [6:0] k, input logic [6:0] vel,
                                      input logic [6:0] raw, input logic [31:0] at_tick);
        t_res r;
        r = '0;
        r.kind = KIND_NOTE;
        r.note_key = k;
        r.velocity = vel;
        if (rec_on) begin
            r.recorded = 1'b1;
            r.delta_ticks = 16'(at_tick - rec_tick);
            r.raw_velocity = raw;
            rec_tick = at_tick;
        end
        r.last = 1'b1;
        events_due.push_back(r);
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic [31:0] at_tick);
        logic [6:0]  k;
        logic        half;
        logic [63:0] key_bit;
        int          scaled;
        t_res        r;
        if (b[7]) begin
            cur_type = b[7:4];
            want_value = 1'b0;
            return;
        end
        if (!want_value) begin
            if (has_value(cur_type)) begin
                key_hold = b;
                want_value = 1'b1;
            end
            return;
        end
        want_value = 1'b0;
        k = key_hold[6:0];
        half = k[6];
        key_bit = 64'd1 << k[5:0];
        if (cur_type == ST_NOTE_ON) begin
            if (b == 8'd0) begin
                if ((keys_down[half] & key_bit) == 64'd0)
                    return;
                keys_down[half] &= ~key_bit;
                if (pedal) begin
                    keys_held[half] |= key_bit;
                    return;
                end
                push_note(k, 7'd0, 7'd0, at_tick);
            end else begin
                scaled = (int'(b) * 4) / 3;
                if (scaled > int'(VEL_MAX))
                    scaled = int'(VEL_MAX);
                keys_held[half] &= ~key_bit;
                keys_down[half] |= key_bit;
                push_note(k, 7'(scaled), b[6:0], at_tick);
            end
        end else if (cur_type == ST_CTRL && k == SUSTAIN_CC) begin
            pedal = (b != 8'd0);
            if (pedal)
                return;
            for (int h = 0; h < 2; h++) begin
                if (keys_held[h] != 64'd0) begin
                    r = '0;
                    r.kind = KIND_MASK;
                    r.mask_half = h[0];
                    r.release_mask = keys_held[h];
                    r.last = (h == 1) || (keys_held[1] == 64'd0);
                    events_due.push_back(r);
                end
            end
            keys_held[0] = '0;
            keys_held[1] = '0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            n_err++;
        end
    endfunction

    // sender: gaps mostly short, a few long, with stretches of back-to-back items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                track_byte(i_s_tdata[7:0], i_s_tdata[39:8]);
                n_bytes++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    drv_item = bytes_to_send.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {drv_item.tick, drv_item.midi};
                    if (tx_calm > 0) begin
                        tx_calm--;
                    end else begin
                        roll = $urandom_range(0, 99);
                        if (roll < 4)
                            tx_calm = $urandom_range(20, 60);
                        else if (roll >= 60 && roll < 92)
                            tx_gap = $urandom_range(1, 3);
                        else if (roll >= 92)
                            tx_gap = $urandom_range(10, 40);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off once results are flowing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (!hold_done && n_results >= 12) begin
                hold_done = 1'b1;
                rx_stall = 300;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else if (rx_calm > 0) begin
                rx_calm--;
                i_m_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    rx_calm = $urandom_range(20, 60);
                if (roll < 65) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= 1'b0;
                    rx_stall = (roll < 94) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind = o_m_tuser;
            got.note_key = o_m_tdata[6:0];
            got.velocity = o_m_tdata[13:7];
            got.recorded = o_m_tdata[14];
            got.delta_ticks = o_m_tdata[30:15];
            got.raw_velocity = o_m_tdata[37:31];
            got.mask_half = o_m_tdata[38];
            got.release_mask = o_m_tdata[102:39];
            got.last = o_m_tlast;
            n_results++;
            if (events_due.size() == 0) begin
                $display("%0t: unexpected item, expected none actual kind %0b tdata %h",
                         $time, got.kind, o_m_tdata);
                n_err++;
            end else begin
                want = events_due.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("note_key", want.note_key, got.note_key);
                check_field("velocity", want.velocity, got.velocity);
                check_field("recorded", want.recorded, got.recorded);
                check_field("delta_ticks", want.delta_ticks, got.delta_ticks);
                check_field("raw_velocity", want.raw_velocity, got.raw_velocity);
                check_field("mask_half", want.mask_half, got.mask_half);
                check_field("release_mask", want.release_mask, got.release_mask);
                check_field("last", want.last, got.last);
                if (want.kind == KIND_MASK)
                    n_masks++;
                else
                    n_notes++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d items still due", $time, events_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(input logic [7:0] b);
        t_midi_in it;
        it.midi = b;
        it.tick = tick_now;
        bytes_to_send.push_back(it);
        if ($urandom_range(0, 7) == 0)
            tick_now = $urandom;
        else
            tick_now += $urandom_range(0, 300);
        if (b[7])
            gen_type = b[7:4];
    endtask

    task automatic settle();
        while (!(bytes_to_send.size() == 0 && !i_s_tvalid && events_due.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_recording(input logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        rec_on = v;
        n_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 127));
            1: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd127;
            default: return 8'($urandom_range(60, 67));
        endcase
    endfunction

    task automatic random_message();
        int          sel;
        logic [3:0]  ty;
        logic [7:0]  key;
        logic [7:0]  val;
        sel = $urandom_range(0, 99);
        if (sel < 4) begin
            send(8'($urandom_range(0, 127)));
            return;
        end
        if (sel < 8) begin
            send({ST_SYSTEM, 4'($urandom)});
            return;
        end
        if (sel < 13) begin
            ty = ($urandom_range(0, 1) == 0) ? ST_PROGRAM : ST_CHAN_PRS;
            send({ty, 4'($urandom)});
            send(8'($urandom_range(0, 127)));
            return;
        end
        if (sel < 60)      ty = ST_NOTE_ON;
        else if (sel < 75) ty = ST_CTRL;
        else if (sel < 84) ty = ST_NOTE_OFF;
        else if (sel < 92) ty = ST_AFTER;
        else               ty = ST_BEND;
        if (ty != gen_type || $urandom_range(0, 3) == 0)
            send({ty, 4'($urandom)});
        if (ty == ST_CTRL) begin
            key = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127)) : 8'(SUSTAIN_CC);
            val = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 127));
        end else begin
            key = pick_key();
            val = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(0, 127));
        end
        send(key);
        // truncated message now and then
        if ($urandom_range(0, 19) == 0)
            send({ty, 4'($urandom)});
        send(val);
    endtask

    task automatic random_phase(input int n);
        int start;
        start = bytes_to_send.size();
        while (bytes_to_send.size() - start < n)
            random_message();
    endtask

    task automatic directed_bytes();
        tick_now = 32'hFFFF_FFF0;
        send({ST_NOTE_ON, 4'h0});
        send(8'd0);   send(8'd127);                 // lowest key, top velocity
        send(8'd127); send(8'd1);                   // highest key, lowest velocity
        send(8'd60);  send(8'd96);                  // saturates
        send(8'd60);  send(8'd95);                  // press of a pressed key
        send(8'd5);   send(8'd0);                   // release of an unpressed key
        send({ST_CTRL, 4'hF});
        send(8'(SUSTAIN_CC)); send(8'd100);         // pedal down
        send({ST_NOTE_ON, 4'h3});
        send(8'd0);   send(8'd0);                   // deferred by the pedal
        send(8'd127); send(8'd0);
        send(8'd60);  send(8'd0);
        send(8'd60);  send(8'd50);                  // press of a sustained key
        send({ST_CTRL, 4'h0});
        send(8'(CC_VOLUME)); send(8'd55);
        send(8'(SUSTAIN_CC)); send(8'd0);           // pedal up, both halves
        send({ST_PROGRAM, 4'h1}); send(8'd33);      // no value byte
        send(8'hF8);
        send({ST_AFTER, 4'h2}); send(8'd1);
        send({ST_NOTE_OFF, 4'h2}); send(8'd60); send(8'd64);
        send({ST_BEND, 4'hE}); send(8'd3); send(8'd4);
        send({ST_NOTE_ON, 4'h0}); send(8'd60); send(8'd0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_recording(1'b1);
        directed_bytes();
        random_phase(170);
        settle();

        set_recording(1'b0);
        random_phase(170);
        settle();

        set_recording(1'b1);
        random_phase(170);
        settle();

        set_recording(1'b0);
        random_phase(170);
        settle();

        if (events_due.size() != 0) begin
            $display("%0t: %0d items never arrived", $time, events_due.size());
            n_err++;
        end
        $display("Sent %0d MIDI bytes over %0d record settings, long output hold-off %0s",
                 n_bytes, n_writes, hold_done ? "done" : "missed");
        $display("Checked %0d note events and %0d pedal release masks, %0d errors",
                 n_notes, n_masks, n_err);
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
